// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;

   localparam logic [1:0] KindFull     = 2'd0;
   localparam logic [1:0] KindPadOpen  = 2'd1;
   localparam logic [1:0] KindPadClose = 2'd2;
   localparam logic [1:0] KindTail     = 2'd3;

   localparam logic [5:0] LastFill  = 6'd63;
   localparam logic [5:0] LengthPos = 6'd56;
   localparam logic [7:0] PadByte   = 8'h80;

   typedef struct packed {
      logic       load;
      logic       round;
      logic [5:0] round_idx;
      logic       update;
      logic       restart;
   } core_ctl_type;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      unique case (idx)
         3'd0: init_hash = 32'h6a09e667;
         3'd1: init_hash = 32'hbb67ae85;
         3'd2: init_hash = 32'h3c6ef372;
         3'd3: init_hash = 32'ha54ff53a;
         3'd4: init_hash = 32'h510e527f;
         3'd5: init_hash = 32'h9b05688c;
         3'd6: init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   function automatic word_type round_const(input logic [5:0] idx);
      unique case (idx)
         6'd0:  round_const = 32'h428a2f98;
         6'd1:  round_const = 32'h71374491;
         6'd2:  round_const = 32'hb5c0fbcf;
         6'd3:  round_const = 32'he9b5dba5;
         6'd4:  round_const = 32'h3956c25b;
         6'd5:  round_const = 32'h59f111f1;
         6'd6:  round_const = 32'h923f82a4;
         6'd7:  round_const = 32'hab1c5ed5;
         6'd8:  round_const = 32'hd807aa98;
         6'd9:  round_const = 32'h12835b01;
         6'd10: round_const = 32'h243185be;
         6'd11: round_const = 32'h550c7dc3;
         6'd12: round_const = 32'h72be5d74;
         6'd13: round_const = 32'h80deb1fe;
         6'd14: round_const = 32'h9bdc06a7;
         6'd15: round_const = 32'hc19bf174;
         6'd16: round_const = 32'he49b69c1;
         6'd17: round_const = 32'hefbe4786;
         6'd18: round_const = 32'h0fc19dc6;
         6'd19: round_const = 32'h240ca1cc;
         6'd20: round_const = 32'h2de92c6f;
         6'd21: round_const = 32'h4a7484aa;
         6'd22: round_const = 32'h5cb0a9dc;
         6'd23: round_const = 32'h76f988da;
         6'd24: round_const = 32'h983e5152;
         6'd25: round_const = 32'ha831c66d;
         6'd26: round_const = 32'hb00327c8;
         6'd27: round_const = 32'hbf597fc7;
         6'd28: round_const = 32'hc6e00bf3;
         6'd29: round_const = 32'hd5a79147;
         6'd30: round_const = 32'h06ca6351;
         6'd31: round_const = 32'h14292967;
         6'd32: round_const = 32'h27b70a85;
         6'd33: round_const = 32'h2e1b2138;
         6'd34: round_const = 32'h4d2c6dfc;
         6'd35: round_const = 32'h53380d13;
         6'd36: round_const = 32'h650a7354;
         6'd37: round_const = 32'h766a0abb;
         6'd38: round_const = 32'h81c2c92e;
         6'd39: round_const = 32'h92722c85;
         6'd40: round_const = 32'ha2bfe8a1;
         6'd41: round_const = 32'ha81a664b;
         6'd42: round_const = 32'hc24b8b70;
         6'd43: round_const = 32'hc76c51a3;
         6'd44: round_const = 32'hd192e819;
         6'd45: round_const = 32'hd6990624;
         6'd46: round_const = 32'hf40e3585;
         6'd47: round_const = 32'h106aa070;
         6'd48: round_const = 32'h19a4c116;
         6'd49: round_const = 32'h1e376c08;
         6'd50: round_const = 32'h2748774c;
         6'd51: round_const = 32'h34b0bcb5;
         6'd52: round_const = 32'h391c0cb3;
         6'd53: round_const = 32'h4ed8aa4a;
         6'd54: round_const = 32'h5b9cca4f;
         6'd55: round_const = 32'h682e6ff3;
         6'd56: round_const = 32'h748f82ee;
         6'd57: round_const = 32'h78a5636f;
         6'd58: round_const = 32'h84c87814;
         6'd59: round_const = 32'h8cc70208;
         6'd60: round_const = 32'h90befffa;
         6'd61: round_const = 32'ha4506ceb;
         6'd62: round_const = 32'hbef9a3f7;
         default: round_const = 32'hc67178f2;
      endcase
   endfunction

endpackage

// ----- rtl/sha256_message_digest.sv -----
// SHA-256 message digest.
// Input channel req_*: one transfer per item. req_tdata carries the message byte,
// req_tuser says the byte is part of the message, req_tlast marks the final item.
// An item with req_tuser low and req_tlast low is dropped.
// Result channel rsp_*: one transfer per message, the eight digest words with
// word 0 in the lowest 32 bits of rsp_tdata.
// Bytes go one per cycle into a 16-word block memory. The 64th byte of a block
// starts a compression (the read states StLoadAddr and StLoadData, 64 rounds on
// one round unit, one chaining add); no item is taken meanwhile, so the next
// block's bytes wait until the compression is done.
// The final item appends padding and length while the block is read back; the
// digest is presented after its compression, or after a second block's when one is
// needed. The result sits in an output register; while the receiver stalls the
// block keeps taking items and only holds the next digest until the slot frees.
// After each digest the chaining value returns to the initial hash values.
// Reset clears the byte count and result valid and sets the initial hash values.
module sha256_message_digest (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tuser,   // [0] has_byte
   input  logic          req_tlast,   // end_of_message
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [255:0]  rsp_tdata    // digest_word_0 [31:0] .. digest_word_7 [255:224]
);

   localparam logic [2:0] StIdle     = 3'd0;
   localparam logic [2:0] StLoadAddr = 3'd1;
   localparam logic [2:0] StLoadData = 3'd2;
   localparam logic [2:0] StRound    = 3'd3;
   localparam logic [2:0] StUpdate   = 3'd4;
   localparam logic [2:0] StDigest   = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [60:0]  count_ff, count_in;
   logic [1:0]   kind_ff, kind_in;
   logic         last_ff, last_in;
   logic [5:0]   round_ff, round_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [255:0] rsp_data_ff, rsp_data_in;

   logic                     req_xfer;
   logic                     wr_en;
   logic [5:0]               fill_now;
   logic [5:0]               fill_after;
   logic [5:0]               rd_next;
   logic [3:0]               rd_addr;
   sha256_pkg::word_type     rd_word;
   sha256_pkg::hash_type     chain;
   sha256_pkg::core_ctl_type ctl;

   assign req_tready = (state_ff == StIdle);
   assign req_xfer   = req_tvalid && req_tready;
   assign fill_now   = count_ff[5:0];
   assign wr_en      = req_xfer && req_tuser;
   assign fill_after = req_tuser ? fill_now + 6'd1 : fill_now;
   assign rd_next    = round_ff + 6'd2;

   always_comb begin
      unique case (state_ff)
         StLoadAddr: rd_addr = 4'd0;
         StLoadData: rd_addr = 4'd1;
         default:    rd_addr = rd_next[3:0];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;
      ctl.round_idx = round_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               if (req_tuser) begin
                  count_in = count_ff + 61'd1;
               end
               priority if (req_tuser && fill_now == sha256_pkg::LastFill) begin
                  kind_in  = sha256_pkg::KindFull;
                  last_in  = req_tlast;
                  state_in = StLoadAddr;
               end else if (req_tlast) begin
                  kind_in  = (fill_after >= sha256_pkg::LengthPos) ?
                             sha256_pkg::KindPadOpen : sha256_pkg::KindPadClose;
                  last_in  = 1'b1;
                  state_in = StLoadAddr;
               end else begin
                  state_in = StIdle;
               end
            end
         end
         StLoadAddr: begin
            state_in = StLoadData;
         end
         StLoadData: begin
            ctl.load = 1'b1;
            round_in = '0;
            state_in = StRound;
         end
         StRound: begin
            ctl.round = 1'b1;
            round_in  = round_ff + 6'd1;
            if (round_ff == sha256_pkg::LastFill) begin
               state_in = StUpdate;
            end
         end
         StUpdate: begin
            ctl.update = 1'b1;
            unique case (kind_ff)
               sha256_pkg::KindFull: begin
                  if (last_ff) begin
                     kind_in  = sha256_pkg::KindPadClose;
                     state_in = StLoadAddr;
                  end else begin
                     state_in = StIdle;
                  end
               end
               sha256_pkg::KindPadOpen: begin
                  kind_in  = sha256_pkg::KindTail;
                  state_in = StLoadAddr;
               end
               default: begin
                  state_in = StDigest;
               end
            endcase
         end
         StDigest: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = chain;
               ctl.restart  = 1'b1;
               count_in     = '0;
               last_in      = 1'b0;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         kind_ff      <= sha256_pkg::KindFull;
         last_ff      <= 1'b0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         kind_ff      <= kind_in;
         last_ff      <= last_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   sha256_buffer u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_now),
      .wr_byte (req_tdata),
      .rd_addr (rd_addr),
      .kind    (kind_ff),
      .fill    (fill_now),
      .bit_len ({count_ff, 3'b000}),
      .rd_word (rd_word)
   );

   sha256_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .word_in   (rd_word),
      .chain_out (chain)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/sha256_buffer.sv -----
module sha256_buffer (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [5:0]                wr_addr,
   input  logic [7:0]                wr_byte,
   input  logic [3:0]                rd_addr,
   input  logic [1:0]                kind,
   input  logic [5:0]                fill,
   input  logic [63:0]               bit_len,
   output sha256_pkg::word_type      rd_word
);

   sha256_pkg::word_type blk_mem_ff [16];
   sha256_pkg::word_type rd_data_ff;
   logic [3:0]           rd_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         blk_mem_ff[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
      rd_data_ff <= blk_mem_ff[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // build padding and length on the fly over the stored bytes
   always_comb begin
      logic [5:0] pos;
      logic [1:0] lane;
      logic       padded;
      logic       closing;
      padded  = (kind == sha256_pkg::KindPadOpen) || (kind == sha256_pkg::KindPadClose);
      closing = (kind == sha256_pkg::KindPadClose) || (kind == sha256_pkg::KindTail);
      rd_word = '0;
      for (int l = 0; l < 4; l++) begin
         lane = 2'(l);
         pos  = {rd_idx_ff, lane};
         priority if (kind == sha256_pkg::KindFull || (padded && pos < fill)) begin
            rd_word[{~lane, 3'b000} +: 8] = rd_data_ff[{~lane, 3'b000} +: 8];
         end else if (padded && pos == fill) begin
            rd_word[{~lane, 3'b000} +: 8] = sha256_pkg::PadByte;
         end else begin
            rd_word[{~lane, 3'b000} +: 8] = 8'h00;
         end
      end
      if (closing && rd_idx_ff == sha256_pkg::LengthPos[5:2]) begin
         rd_word = bit_len[63:32];
      end else if (closing && rd_idx_ff == 4'(sha256_pkg::LengthPos[5:2] + 4'd1)) begin
         rd_word = bit_len[31:0];
      end
   end

endmodule

// ----- rtl/sha256_core.sv -----
module sha256_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::core_ctl_type  ctl,
   input  sha256_pkg::word_type      word_in,
   output sha256_pkg::hash_type      chain_out
);

   sha256_pkg::hash_type chain_ff;
   sha256_pkg::hash_type vars_ff;
   sha256_pkg::hash_type vars_in;
   sha256_pkg::word_type win_ff [16];
   sha256_pkg::word_type wt_ff;
   sha256_pkg::word_type w_next;

   always_comb begin
      sha256_pkg::word_type t1;
      sha256_pkg::word_type t2;
      sha256_pkg::word_type ch;
      sha256_pkg::word_type maj;
      ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]);
      t1  = vars_ff[7] + sha256_pkg::big_sigma1(vars_ff[4]) + ch
            + sha256_pkg::round_const(ctl.round_idx) + wt_ff;
      t2  = sha256_pkg::big_sigma0(vars_ff[0]) + maj;
      vars_in[7] = vars_ff[6];
      vars_in[6] = vars_ff[5];
      vars_in[5] = vars_ff[4];
      vars_in[4] = vars_ff[3] + t1;
      vars_in[3] = vars_ff[2];
      vars_in[2] = vars_ff[1];
      vars_in[1] = vars_ff[0];
      vars_in[0] = t1 + t2;
      w_next = sha256_pkg::small_sigma1(win_ff[15]) + win_ff[10]
               + sha256_pkg::small_sigma0(win_ff[2]) + win_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.restart) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha256_pkg::init_hash(3'(i));
         end
      end else if (ctl.update) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + vars_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         vars_ff <= chain_ff;
         wt_ff   <= word_in;
      end else if (ctl.round) begin
         vars_ff <= vars_in;
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= wt_ff;
         wt_ff      <= (ctl.round_idx < 6'd15) ? word_in : w_next;
      end
   end

   assign chain_out = chain_ff;

endmodule
